// ===== rtl/rrts_pkg.sv =====
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// no dependencies; used by rrts_table and round_robin_thread_scheduler
`default_nettype none

package rrts_pkg;

   localparam int ACT_W = 3;
   localparam int ID_W  = 3;
   localparam int AMT_W = 16;
   localparam int ST_W  = 3;

   typedef logic [ST_W-1:0]  slot_state_type;
   typedef logic [ACT_W-1:0] action_type;

   localparam slot_state_type ST_INVALID  = 3'd0;
   localparam slot_state_type ST_READY    = 3'd1;
   localparam slot_state_type ST_RUNNING  = 3'd2;
   localparam slot_state_type ST_SLEEPING = 3'd3;
   localparam slot_state_type ST_BLOCKED  = 3'd4;

   localparam action_type ACT_START  = 3'd0;
   localparam action_type ACT_YIELD  = 3'd1;
   localparam action_type ACT_SLEEP  = 3'd2;
   localparam action_type ACT_KILL   = 3'd3;
   localparam action_type ACT_BLOCK  = 3'd4;
   localparam action_type ACT_RESUME = 3'd5;
   localparam action_type ACT_TICK   = 3'd6;

   typedef struct packed {
      logic             st_we;
      logic             sl_we;
      slot_state_type   st;
      logic [AMT_W-1:0] sl;
   } tbl_wr_type;

   typedef struct packed {
      slot_state_type   st;
      logic [AMT_W-1:0] sl;
   } tbl_rd_type;

endpackage

`default_nettype wire

// ===== rtl/rrts_table.sv =====
// rrts_table: slot state and sleep count memories, one read and one write port each
// read data registered; entries never written read as their reset values
// depends on rrts_pkg
`default_nettype none

module rrts_table #(
   parameter int POOL_SIZE = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(POOL_SIZE)-1:0] rd_addr,
   output rrts_pkg::tbl_rd_type              rd_data,
   input  wire logic [$clog2(POOL_SIZE)-1:0] wr_addr,
   input  wire rrts_pkg::tbl_wr_type         wr
);
   import rrts_pkg::*;

   localparam int IDXW = $clog2(POOL_SIZE);

   slot_state_type   st_mem [POOL_SIZE];
   logic [AMT_W-1:0] sl_mem [POOL_SIZE];

   logic [POOL_SIZE-1:0] st_vld_ff, st_vld_in;
   logic [POOL_SIZE-1:0] sl_vld_ff, sl_vld_in;

   slot_state_type   st_q_ff;
   logic [AMT_W-1:0] sl_q_ff;
   logic             st_hit_ff;
   logic             sl_hit_ff;
   logic [IDXW-1:0]  idx_ff;

   always_ff @(posedge clock) begin
      if (wr.st_we) begin
         st_mem[wr_addr] <= wr.st;
      end
      if (wr.sl_we) begin
         sl_mem[wr_addr] <= wr.sl;
      end
      if (rd_en) begin
         st_q_ff   <= st_mem[rd_addr];
         sl_q_ff   <= sl_mem[rd_addr];
         st_hit_ff <= st_vld_ff[rd_addr];
         sl_hit_ff <= sl_vld_ff[rd_addr];
         idx_ff    <= rd_addr;
      end
   end

   always_comb begin
      st_vld_in = st_vld_ff;
      sl_vld_in = sl_vld_ff;
      if (wr.st_we) begin
         st_vld_in[wr_addr] = 1'b1;
      end
      if (wr.sl_we) begin
         sl_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff <= '0;
         sl_vld_ff <= '0;
      end else begin
         st_vld_ff <= st_vld_in;
         sl_vld_ff <= sl_vld_in;
      end
   end

   // slot 0 comes out of reset running, all others invalid
   always_comb begin
      if (st_hit_ff) begin
         rd_data.st = st_q_ff;
      end else if (idx_ff == '0) begin
         rd_data.st = ST_RUNNING;
      end else begin
         rd_data.st = ST_INVALID;
      end
      rd_data.sl = sl_hit_ff ? sl_q_ff : '0;
   end

endmodule

`default_nettype wire

// ===== rtl/round_robin_thread_scheduler.sv =====
// round_robin_thread_scheduler: command sequencer around the slot table
// depends on rrts_pkg and rrts_table
//
//   channel   ports                                   transfer
//   command   start busy req_action req_thread_id     start && !busy
//             req_amount
//   result    rsp_strobe rsp_running_id rsp_new_slot  rsp_strobe, one cycle
//             rsp_status rsp_switched
//
// one command at a time; every slot visit is one access on the table read port
// resume and unused codes end in the decode state; start scans for a free slot;
// yield/sleep/kill/block pick the next ready slot; tick ages all sleepers, then picks
// busy stays high from the transfer until the cycle the result strobe shows
// synchronous reset clears control and the table valid bits; no clearing pass
// results cannot be stalled; a new command is taken while the strobe is high
`default_nettype none

module round_robin_thread_scheduler #(
   parameter int POOL_SIZE = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [rrts_pkg::ACT_W-1:0] req_action,
   input  wire logic [rrts_pkg::ID_W-1:0]  req_thread_id,
   input  wire logic [rrts_pkg::AMT_W-1:0] req_amount,
   output logic                            rsp_strobe,
   output logic [rrts_pkg::ID_W-1:0]       rsp_running_id,
   output logic [rrts_pkg::ID_W-1:0]       rsp_new_slot,
   output logic                            rsp_status,
   output logic                            rsp_switched
);
   import rrts_pkg::*;

   localparam int IDXW = $clog2(POOL_SIZE);
   localparam int CNTW = IDXW + 1;
   localparam logic [CNTW-1:0] CNT_N    = CNTW'(POOL_SIZE);
   localparam logic [IDXW-1:0] IDX_LAST = IDXW'(POOL_SIZE - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_FREE = 3'd2;
   localparam logic [2:0] S_TICK = 3'd3;
   localparam logic [2:0] S_PICK = 3'd4;
   localparam logic [2:0] S_SWAP = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic [IDXW-1:0] cur_ff, cur_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [IDXW-1:0] pick_ff, pick_in;
   logic            cur_run_ff, cur_run_in;
   logic            dv_ff;
   logic [IDXW-1:0] idx_ff;
   logic [IDXW-1:0] ord_ff;

   action_type       act_ff;
   logic [ID_W-1:0]  tid_ff;
   logic [AMT_W-1:0] amt_ff;

   logic            rsp_strobe_ff;
   logic [ID_W-1:0] rsp_running_id_ff;
   logic [ID_W-1:0] rsp_new_slot_ff;
   logic            rsp_status_ff;
   logic            rsp_switched_ff;

   logic            rd_en;
   logic [IDXW-1:0] rd_addr;
   logic [IDXW-1:0] wr_addr;
   tbl_wr_type      wr;
   tbl_rd_type      rd;

   logic            accept;
   logic            done;
   logic [IDXW-1:0] out_new;
   logic            out_status;
   logic            out_sw;

   logic                 tid_ok;
   logic [IDXW+ID_W-1:0] tid_ext;
   logic [IDXW-1:0]      tid_idx;
   logic [CNTW-1:0]      pick_sum;
   logic [CNTW-1:0]      pick_wrap;
   logic [IDXW+ID_W-1:0] cur_ext;
   logic [IDXW+ID_W-1:0] new_ext;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   assign tid_ok  = (int'(tid_ff) < POOL_SIZE);
   assign tid_ext = {{IDXW{1'b0}}, tid_ff};
   assign tid_idx = tid_ext[IDXW-1:0];

   assign pick_sum  = {1'b0, cur_ff} + cnt_ff;
   assign pick_wrap = (pick_sum >= CNT_N) ? (pick_sum - CNT_N) : pick_sum;

   assign cur_ext = {{ID_W{1'b0}}, cur_in};
   assign new_ext = {{ID_W{1'b0}}, out_new};

   rrts_table #(
      .POOL_SIZE(POOL_SIZE)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd),
      .wr_addr (wr_addr),
      .wr      (wr)
   );

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      cnt_in     = cnt_ff;
      pick_in    = pick_ff;
      cur_run_in = cur_run_ff;
      rd_en      = 1'b0;
      rd_addr    = cnt_ff[IDXW-1:0];
      wr_addr    = cur_ff;
      wr         = '0;
      done       = 1'b0;
      out_new    = '0;
      out_status = 1'b0;
      out_sw     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               state_in = (req_action == ACT_START) ? S_FREE : S_MOD;
            end
         end
         S_MOD: begin
            cnt_in = '0;
            case (act_ff)
               ACT_YIELD: begin
                  state_in = S_PICK;
               end
               ACT_SLEEP: begin
                  wr.st_we = 1'b1;
                  wr.st    = ST_SLEEPING;
                  wr.sl_we = 1'b1;
                  wr.sl    = amt_ff;
                  state_in = S_PICK;
               end
               ACT_KILL: begin
                  wr.st_we = 1'b1;
                  wr.st    = ST_INVALID;
                  state_in = S_PICK;
               end
               ACT_BLOCK: begin
                  wr_addr  = tid_idx;
                  wr.st_we = tid_ok;
                  wr.st    = ST_BLOCKED;
                  state_in = S_PICK;
               end
               ACT_RESUME: begin
                  wr_addr  = tid_idx;
                  wr.st_we = tid_ok;
                  wr.st    = ST_READY;
                  done     = 1'b1;
                  state_in = S_IDLE;
               end
               ACT_TICK: begin
                  state_in = S_TICK;
               end
               default: begin
                  done     = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FREE: begin
            if (dv_ff && rd.st == ST_INVALID) begin
               wr_addr  = idx_ff;
               wr.st_we = 1'b1;
               wr.st    = ST_READY;
               out_new  = idx_ff;
               done     = 1'b1;
               state_in = S_IDLE;
            end else if (dv_ff && ord_ff == IDX_LAST) begin
               out_status = 1'b1;
               done       = 1'b1;
               state_in   = S_IDLE;
            end else if (cnt_ff < CNT_N) begin
               rd_en   = 1'b1;
               rd_addr = cnt_ff[IDXW-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         S_TICK: begin
            if (dv_ff && rd.st == ST_SLEEPING) begin
               wr_addr = idx_ff;
               if (rd.sl > amt_ff) begin
                  wr.sl_we = 1'b1;
                  wr.sl    = rd.sl - amt_ff;
               end else begin
                  wr.st_we = 1'b1;
                  wr.st    = ST_READY;
               end
            end
            if (dv_ff && ord_ff == IDX_LAST) begin
               cnt_in   = '0;
               state_in = S_PICK;
            end else if (cnt_ff < CNT_N) begin
               rd_en   = 1'b1;
               rd_addr = cnt_ff[IDXW-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         S_PICK: begin
            // first read is the running slot itself, then the others in turn
            if (dv_ff && ord_ff == '0) begin
               cur_run_in = (rd.st == ST_RUNNING);
            end
            if (dv_ff && ord_ff != '0 && rd.st == ST_READY) begin
               pick_in  = idx_ff;
               wr_addr  = cur_ff;
               wr.st_we = cur_run_ff;
               wr.st    = ST_READY;
               state_in = S_SWAP;
            end else if (dv_ff && ord_ff == IDX_LAST) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end else if (cnt_ff < CNT_N) begin
               rd_en   = 1'b1;
               rd_addr = pick_wrap[IDXW-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         S_SWAP: begin
            wr_addr  = pick_ff;
            wr.st_we = 1'b1;
            wr.st    = ST_RUNNING;
            cur_in   = pick_ff;
            out_sw   = 1'b1;
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '0;
         cnt_ff        <= '0;
         cur_run_ff    <= 1'b0;
         dv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         cnt_ff        <= cnt_in;
         cur_run_ff    <= cur_run_in;
         dv_ff         <= rd_en;
         rsp_strobe_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff <= pick_in;
      if (accept) begin
         act_ff <= req_action;
         tid_ff <= req_thread_id;
         amt_ff <= req_amount;
      end
      if (rd_en) begin
         idx_ff <= rd_addr;
         ord_ff <= cnt_ff[IDXW-1:0];
      end
      if (done) begin
         rsp_running_id_ff <= cur_ext[ID_W-1:0];
         rsp_new_slot_ff   <= new_ext[ID_W-1:0];
         rsp_status_ff     <= out_status;
         rsp_switched_ff   <= out_sw;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_running_id = rsp_running_id_ff;
   assign rsp_new_slot   = rsp_new_slot_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_switched   = rsp_switched_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while a command is still in work");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command transfer did not raise busy");

   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_switched) |-> !rsp_status)
      else $error("switch reported together with a full pool");

   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      int'(cur_ff) < POOL_SIZE)
      else $error("running slot outside the pool");

endmodule

`default_nettype wire
